// ===== design/compass_heading_from_field_assert.svh =====
// Assertion macros for the compass heading block.
`ifndef COMPASS_HEADING_FROM_FIELD_ASSERT_SVH
`define COMPASS_HEADING_FROM_FIELD_ASSERT_SVH

// Same-cycle implication, clocked on clk, quiet while arst_n is low.
`define CHF_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("compass heading assertion failed");

// Implication with a delayed consequent.
`define CHF_ASSERT_DELAY(label, ante, n, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error("compass heading latency assertion failed");

`endif

// ===== design/chf_pkg.sv =====
// Package: widths, angle constants, arctangent table and register codes.
package chf_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_TAB_LEN     = 24;

	// sample and offset-corrected widths
	localparam int SW  = 16;
	localparam int HXW = 17;
	localparam int HW  = 18;
	localparam int PRE = 14;
	localparam int XW  = 34;   // CORDIC datapath: 18-bit vector, gain, 2^14 prescale
	localparam int ZW  = 17;   // CORDIC angle accumulator
	localparam int AW  = 18;   // angle after declination
	localparam int ATW = 13;   // arctangent table entry

	localparam logic signed [ZW-1:0] ANG_HALF_PI = 17'sd12868;
	localparam logic signed [AW-1:0] ANG_PI      = 18'sd25736;
	localparam logic signed [AW-1:0] ANG_TWO_PI  = 18'sd51472;

	// degrees = |ang| * 45 / 6434 (same as * 180 / 25736)
	localparam int NW       = 21;
	localparam int QW       = 9;
	localparam int RECIP_SH = 32;
	localparam int RW       = 20;
	localparam int PW       = NW + RW;
	localparam logic [5:0]    DEG_NUM = 6'd45;
	localparam logic [NW-1:0] DEG_DEN = 21'd6434;
	localparam logic [RW-1:0] RECIP   = RW'((64'd1 << RECIP_SH) / 64'd6434);
	localparam logic [QW-1:0] FULL_TURN_DEG = 9'd360;

	typedef enum logic [1:0] {
		REG_OFFSET_X    = 2'd0,
		REG_OFFSET_Y    = 2'd1,
		REG_DECLINATION = 2'd2,
		REG_INVERT_Y    = 2'd3
	} reg_idx_t;

	// atan(2^-i) in 2^-13 rad, rounded
	function automatic logic [ATW-1:0] atan_tab(input int unsigned i);
		logic [ATW-1:0] v;
		case (i)
			0:  v = 13'd6434;
			1:  v = 13'd3798;
			2:  v = 13'd2007;
			3:  v = 13'd1019;
			4:  v = 13'd511;
			5:  v = 13'd256;
			6:  v = 13'd128;
			7:  v = 13'd64;
			8:  v = 13'd32;
			9:  v = 13'd16;
			10: v = 13'd8;
			11: v = 13'd4;
			12: v = 13'd2;
			13: v = 13'd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== design/compass_heading_from_field.sv =====
// Compass heading top level: offset correction, pipelined CORDIC atan2, degrees.
//
//  channel   ports                              direction  handshake
//  request   start, busy, x_sample, y_sample    in         taken when start && !busy
//  result    done, bearing                      out        done high one cycle, no stall
//  config    wr_en, wr_index, wr_data           in         written when wr_en high
//
// One request per cycle; busy stays low. A result passes through one stage for offsets,
// one for the quarter-turn pre-rotation, one per CORDIC iteration, then declination,
// wrap, two multiply stages and the output register.
// Reset clears the configuration registers and the valid chain; nothing is stored between requests.
// The receiver cannot stall, so the pipeline never holds.
`include "compass_heading_from_field_assert.svh"

module compass_heading_from_field #(
	parameter int CORDIC_STEPS = chf_pkg::CORDIC_STEPS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic signed [chf_pkg::SW-1:0]  x_sample,
	input  logic signed [chf_pkg::SW-1:0]  y_sample,
	output logic                           done,
	output logic [chf_pkg::QW-1:0]         bearing,
	input  logic                           wr_en,
	input  logic [1:0]                     wr_index,
	input  logic [chf_pkg::SW-1:0]         wr_data
);

	localparam int LATENCY = CORDIC_STEPS + 7;

	// ---------------- configuration registers ----------------
	logic signed [chf_pkg::SW-1:0] offset_x_q, offset_y_q, declination_q;
	logic                          invert_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q    <= '0;
			offset_y_q    <= '0;
			declination_q <= '0;
			invert_y_q    <= 1'b0;
		end else if (wr_en) begin
			unique case (chf_pkg::reg_idx_t'(wr_index))
				chf_pkg::REG_OFFSET_X:    offset_x_q    <= wr_data;
				chf_pkg::REG_OFFSET_Y:    offset_y_q    <= wr_data;
				chf_pkg::REG_DECLINATION: declination_q <= wr_data;
				chf_pkg::REG_INVERT_Y:    invert_y_q    <= wr_data[0];
			endcase
		end
	end

	assign busy = 1'b0;
	logic accept;
	assign accept = start && !busy;

	// ---------------- stage 1: orientation flip and hard-iron offsets ----------------
	logic signed [chf_pkg::HXW-1:0] y_ext, y_sel;
	logic signed [chf_pkg::HXW-1:0] hx_s1;
	logic signed [chf_pkg::HW-1:0]  hy_s1;
	logic                           vld_s1;

	assign y_ext = chf_pkg::HXW'(y_sample);
	assign y_sel = invert_y_q ? -y_ext : y_ext;   // -(-32768) needs the 17th bit

	always_ff @(posedge clk) begin
		hx_s1 <= chf_pkg::HXW'(x_sample) - chf_pkg::HXW'(offset_x_q);
		hy_s1 <= chf_pkg::HW'(y_sel) - chf_pkg::HW'(offset_y_q);
	end

	// ---------------- stage 2: pre-rotation into right half plane ----------------
	// CORDIC arrays: index 0 is stage 2, index i+1 is the result of iteration i.
	logic signed [chf_pkg::XW-1:0] cx_s [0:CORDIC_STEPS];
	logic signed [chf_pkg::XW-1:0] cy_s [0:CORDIC_STEPS];
	logic signed [chf_pkg::ZW-1:0] cz_s [0:CORDIC_STEPS];
	logic                          zero_s [0:CORDIC_STEPS];
	logic                          vld_s [0:CORDIC_STEPS];

	logic signed [chf_pkg::HW-1:0] hx_w, rx, ry;
	logic signed [chf_pkg::ZW-1:0] rz;

	assign hx_w = chf_pkg::HW'(hx_s1);

	always_comb begin
		rx = hx_w;
		ry = hy_s1;
		rz = '0;
		if (hx_w < 0) begin
			if (hy_s1 >= 0) begin
				rx = hy_s1;
				ry = -hx_w;
				rz = chf_pkg::ANG_HALF_PI;
			end else begin
				rx = -hy_s1;
				ry = hx_w;
				rz = -chf_pkg::ANG_HALF_PI;
			end
		end
	end

	always_ff @(posedge clk) begin
		cx_s[0]   <= {{(chf_pkg::XW - chf_pkg::HW - chf_pkg::PRE){rx[chf_pkg::HW-1]}},
			rx, {chf_pkg::PRE{1'b0}}};
		cy_s[0]   <= {{(chf_pkg::XW - chf_pkg::HW - chf_pkg::PRE){ry[chf_pkg::HW-1]}},
			ry, {chf_pkg::PRE{1'b0}}};
		cz_s[0]   <= rz;
		zero_s[0] <= (hx_s1 == '0) && (hy_s1 == '0);
	end

	// ---------------- CORDIC iterations, one per stage ----------------
	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_iter
		logic signed [chf_pkg::XW-1:0] xsh, ysh;
		logic signed [chf_pkg::ZW-1:0] da;

		assign xsh = cx_s[g] >>> g;
		assign ysh = cy_s[g] >>> g;
		assign da  = chf_pkg::ZW'(chf_pkg::atan_tab(g));

		always_ff @(posedge clk) begin
			if (cy_s[g] >= 0) begin
				cx_s[g+1] <= cx_s[g] + ysh;
				cy_s[g+1] <= cy_s[g] - xsh;
				cz_s[g+1] <= cz_s[g] + da;
			end else begin
				cx_s[g+1] <= cx_s[g] - ysh;
				cy_s[g+1] <= cy_s[g] + xsh;
				cz_s[g+1] <= cz_s[g] - da;
			end
			zero_s[g+1] <= zero_s[g];
		end
	end

	// ---------------- tail stages: declination, wrap, degree conversion ----------------
	logic signed [chf_pkg::AW-1:0] ang_sd, ang_sw;
	logic signed [chf_pkg::AW-1:0] cz_ext;
	logic                          vld_sd, vld_sw;

	// zero vector gives angle 0 before declination
	assign cz_ext = zero_s[CORDIC_STEPS] ? '0 : chf_pkg::AW'(cz_s[CORDIC_STEPS]);

	always_ff @(posedge clk) begin
		ang_sd <= cz_ext + chf_pkg::AW'(declination_q);
	end

	// one correction always suffices for the reachable range
	always_ff @(posedge clk) begin
		if (ang_sd < -chf_pkg::ANG_PI)
			ang_sw <= ang_sd + chf_pkg::ANG_TWO_PI;
		else if (ang_sd > chf_pkg::ANG_PI)
			ang_sw <= ang_sd - chf_pkg::ANG_TWO_PI;
		else
			ang_sw <= ang_sd;
	end

	// |ang| * 45, then times reciprocal of 6434
	logic [chf_pkg::AW-1:0] ang_abs;
	logic [chf_pkg::NW-1:0] n_sm1, n_sm2;
	logic [chf_pkg::PW-1:0] p_sm2;
	logic                   neg_sm1, neg_sm2, vld_sm1, vld_sm2;

	assign ang_abs = (ang_sw < 0) ? chf_pkg::AW'(-ang_sw) : chf_pkg::AW'(ang_sw);

	always_ff @(posedge clk) begin
		n_sm1   <= chf_pkg::NW'(ang_abs) * chf_pkg::NW'(chf_pkg::DEG_NUM);
		neg_sm1 <= ang_sw < 0;
		p_sm2   <= chf_pkg::PW'(n_sm1) * chf_pkg::PW'(chf_pkg::RECIP);
		n_sm2   <= n_sm1;
		neg_sm2 <= neg_sm1;
	end

	// quotient estimate is exact or one low
	logic [chf_pkg::QW-1:0] q_est, q_fix;
	logic [chf_pkg::NW-1:0] rem;

	assign q_est = p_sm2[chf_pkg::RECIP_SH +: chf_pkg::QW];
	assign rem   = n_sm2 - chf_pkg::NW'(q_est) * chf_pkg::DEG_DEN;
	assign q_fix = (rem >= chf_pkg::DEG_DEN) ? q_est + chf_pkg::QW'(1) : q_est;

	logic [chf_pkg::QW-1:0] heading_q;
	logic                   done_q;

	always_ff @(posedge clk) begin
		heading_q <= (neg_sm2 && (q_fix != '0)) ? chf_pkg::FULL_TURN_DEG - q_fix : q_fix;
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_sd  <= 1'b0;
			vld_sw  <= 1'b0;
			vld_sm1 <= 1'b0;
			vld_sm2 <= 1'b0;
			done_q  <= 1'b0;
			for (int k = 0; k <= CORDIC_STEPS; k++)
				vld_s[k] <= 1'b0;
		end else begin
			vld_s1   <= accept;
			vld_s[0] <= vld_s1;
			for (int k = 0; k < CORDIC_STEPS; k++)
				vld_s[k+1] <= vld_s[k];
			vld_sd  <= vld_s[CORDIC_STEPS];
			vld_sw  <= vld_sd;
			vld_sm1 <= vld_sw;
			vld_sm2 <= vld_sm1;
			done_q  <= vld_sm2;
		end
	end

	assign done    = done_q;
	assign bearing = heading_q;

	// ---------------- assertions ----------------
	`CHF_ASSERT_IMPL(a_wrap_range, vld_sw,
		(ang_sw >= -chf_pkg::ANG_PI) && (ang_sw <= chf_pkg::ANG_PI))
	`CHF_ASSERT_IMPL(a_deg_half_turn, vld_sm2, q_fix <= 9'd180)
	`CHF_ASSERT_IMPL(a_heading_range, done, bearing < chf_pkg::FULL_TURN_DEG)
	`CHF_ASSERT_DELAY(a_latency, accept, LATENCY, done)

endmodule
